### rtl/lmars_pkg.sv
// ----------------------------------------------------------------------------
// lmars_pkg
// Types, widths and helpers shared by the linear move axis rate split.
// ----------------------------------------------------------------------------
package lmars_pkg;

   localparam int AXES    = 3;
   localparam int MAG_W   = 33;   // |to - from|
   localparam int SQ_W    = 66;   // square of one delta
   localparam int ROOT_W  = 34;   // path length bits resolved by the root
   localparam int REM_W   = 68;   // root remainder and trial width
   localparam int NUM_W   = 96;   // delta * tool * scale
   localparam int DEN_W   = 50;   // length << 16
   localparam int Q_W     = 33;   // quotient bits resolved by the divider
   localparam int LATENCY = 75;   // register levels from input to result

   typedef enum logic [2:0] {
      REG_TOOL_SPEED = 3'd0,
      REG_TOOL_ACCEL = 3'd1,
      REG_X_SCALE    = 3'd2,
      REG_Y_SCALE    = 3'd3,
      REG_Z_SCALE    = 3'd4,
      REG_X_LIMITS   = 3'd5,
      REG_Y_LIMITS   = 3'd6,
      REG_Z_LIMITS   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [AXES-1:0]            neg;
      logic [AXES-1:0][MAG_W-1:0] mag;
   } side_type;

   typedef struct packed {
      logic [31:0] tool_speed;
      logic [31:0] tool_accel;
      logic [31:0] scale;
      logic [31:0] vel_lim;
      logic [31:0] acc_lim;
   } axis_cfg_type;

   typedef struct packed {
      logic flip;
      logic zero;
   } div_side_type;

   function automatic logic [31:0] lmars_clamp(input logic [Q_W-1:0] q,
                                               input logic ovf,
                                               input logic flip,
                                               input logic zero,
                                               input logic [31:0] lim);
      logic [31:0] mag;
      logic [31:0] res;
      if (ovf || q[Q_W-1] || (q[31:0] > lim)) mag = lim;
      else mag = q[31:0];
      if (zero || (mag == 32'd0)) res = 32'd0;
      else if (flip) res = (mag > 32'h8000_0000) ? 32'h8000_0000 : (~mag + 32'd1);
      else res = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
      return res;
   endfunction

endpackage

### rtl/lmars_front.sv
// ----------------------------------------------------------------------------
// lmars_front
// One axis lane front end: signed delta, magnitude and its square.
// ----------------------------------------------------------------------------
module lmars_front (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [31:0]                    from_pos,
   input  logic [31:0]                    to_pos,
   output logic                           neg,
   output logic [lmars_pkg::MAG_W-1:0]    mag,
   output logic [lmars_pkg::SQ_W-1:0]     sq
);
   import lmars_pkg::*;

   logic [MAG_W-1:0] diff;
   logic             neg1_in, neg1_ff, neg2_ff;
   logic [MAG_W-1:0] mag1_in, mag1_ff, mag2_ff;
   logic [63:0]      prod;
   logic [SQ_W-1:0]  sq_in, sq_ff;

   always_comb begin
      diff    = {to_pos[31], to_pos} - {from_pos[31], from_pos};
      neg1_in = diff[MAG_W-1];
      mag1_in = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
      prod    = mag1_ff[31:0] * mag1_ff[31:0];
      // magnitude 2^32 has zero low bits
      sq_in   = mag1_ff[MAG_W-1] ? (SQ_W'(1) << 64) : SQ_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
         sq_ff   <= sq_in;
      end
   end

   assign neg = neg2_ff;
   assign mag = mag2_ff;
   assign sq  = sq_ff;

endmodule

### rtl/lmars_isqrt.sv
// ----------------------------------------------------------------------------
// lmars_isqrt
// Merge stage: sums the lane squares and takes the integer root, one bit
// per pipeline stage, carrying the lane data alongside.
// ----------------------------------------------------------------------------
module lmars_isqrt (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [lmars_pkg::SQ_W-1:0]   sq [lmars_pkg::AXES],
   input  lmars_pkg::side_type          side_in,
   output logic [lmars_pkg::ROOT_W-1:0] len,
   output lmars_pkg::side_type          side_out
);
   import lmars_pkg::*;

   logic [REM_W-1:0]  sum_in;
   logic [REM_W-1:0]  rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   side_type          side_ff [ROOT_W+1];

   assign sum_in = REM_W'(sq[0]) + REM_W'(sq[1]) + REM_W'(sq[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= sum_in;
         root_ff[0] <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
      localparam int B = ROOT_W - 1 - k;
      logic [REM_W-1:0]  trial;
      logic              fit;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         trial   = (REM_W'(root_ff[k]) << (B + 1)) | (REM_W'(1) << (2 * B));
         fit     = (trial <= rem_ff[k]);
         rem_in  = fit ? (rem_ff[k] - trial) : rem_ff[k];
         root_in = fit ? (root_ff[k] | (ROOT_W'(1) << B)) : root_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign len      = root_ff[ROOT_W];
   assign side_out = side_ff[ROOT_W];

endmodule

### rtl/lmars_div.sv
// ----------------------------------------------------------------------------
// lmars_div
// Pipelined restoring divider: 96-bit numerator by a 50-bit divisor,
// 33 quotient bits with an overflow flag, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lmars_div (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [lmars_pkg::NUM_W-1:0] num,
   input  logic [lmars_pkg::DEN_W-1:0] den,
   input  lmars_pkg::div_side_type     side_in,
   output logic [lmars_pkg::Q_W-1:0]   quo,
   output logic                        ovf,
   output lmars_pkg::div_side_type     side_out
);
   import lmars_pkg::*;

   logic             ovf_in;
   logic [DEN_W-1:0] r_ff    [Q_W+1];
   logic [Q_W-1:0]   nlo_ff  [Q_W+1];
   logic [Q_W-1:0]   q_ff    [Q_W+1];
   logic [DEN_W-1:0] den_ff  [Q_W+1];
   logic             ovf_ff  [Q_W+1];
   div_side_type     side_ff [Q_W+1];

   // quotient of 2^33 or more saturates anyway
   assign ovf_in = (num >= {{(NUM_W-DEN_W-Q_W){1'b0}}, den, {Q_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]    <= num[DEN_W+Q_W-1:Q_W];
         nlo_ff[0]  <= num[Q_W-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= den;
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_bit
      localparam int I = Q_W - 1 - k;
      logic [DEN_W:0]   t;
      logic             ge;
      logic [DEN_W:0]   diff;
      logic [DEN_W-1:0] r_in;
      logic [Q_W-1:0]   q_in;

      always_comb begin
         t    = {r_ff[k], nlo_ff[k][I]};
         diff = t - {1'b0, den_ff[k]};
         ge   = (t >= {1'b0, den_ff[k]});
         r_in = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
         q_in = q_ff[k] | (Q_W'(ge) << I);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k+1]    <= r_in;
            nlo_ff[k+1]  <= nlo_ff[k];
            q_ff[k+1]    <= q_in;
            den_ff[k+1]  <= den_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign quo      = q_ff[Q_W];
   assign ovf      = ovf_ff[Q_W];
   assign side_out = side_ff[Q_W];

endmodule

### rtl/lmars_axis.sv
// ----------------------------------------------------------------------------
// lmars_axis
// One axis lane back end: delta * tool * scale, division by the path
// length, then limit clamp for both the speed and the acceleration.
// ----------------------------------------------------------------------------
module lmars_axis (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [lmars_pkg::ROOT_W-1:0] len,
   input  logic                         neg,
   input  logic [lmars_pkg::MAG_W-1:0]  mag,
   input  lmars_pkg::axis_cfg_type      cfg,
   output logic [31:0]                  rate,
   output logic [31:0]                  ramp,
   output logic                         zero
);
   import lmars_pkg::*;

   logic [31:0]       tool    [2];
   logic              tneg    [2];
   logic [31:0]       tmag    [2];
   logic [63:0]       p_in    [2];
   logic [63:0]       p_ff    [2];
   logic              flip1_ff [2];
   logic              flip2_ff [2];
   logic              flip3_ff [2];
   logic [63:0]       pl_ff   [2];
   logic [63:0]       ph_ff   [2];
   logic [NUM_W-1:0]  n_ff    [2];
   logic              zero1_ff, zero2_ff, zero3_ff;
   logic [ROOT_W-1:0] len1_ff, len2_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [Q_W-1:0]    quo     [2];
   logic              ovf     [2];
   div_side_type      dside_in  [2];
   div_side_type      dside_out [2];
   logic [31:0]       rate_in, ramp_in;
   logic [31:0]       rate_ff, ramp_ff;
   logic              zero_ff;

   always_comb begin
      tool[0] = cfg.tool_speed;
      tool[1] = cfg.tool_accel;
      for (int j = 0; j < 2; j++) begin
         tneg[j] = tool[j][31];
         tmag[j] = tneg[j] ? (~tool[j] + 32'd1) : tool[j];
         p_in[j] = (64'(mag[31:0]) * 64'(tmag[j]))
                 + (mag[MAG_W-1] ? {tmag[j], 32'd0} : 64'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero1_ff <= (len == '0);
         len1_ff  <= len;
         zero2_ff <= zero1_ff;
         len2_ff  <= len1_ff;
         zero3_ff <= zero2_ff;
         den_ff   <= {len2_ff[DEN_W-17:0], 16'd0};
         for (int j = 0; j < 2; j++) begin
            p_ff[j]     <= p_in[j];
            flip1_ff[j] <= neg ^ tneg[j];
            pl_ff[j]    <= p_ff[j][31:0] * cfg.scale;
            ph_ff[j]    <= p_ff[j][63:32] * cfg.scale;
            flip2_ff[j] <= flip1_ff[j];
            n_ff[j]     <= NUM_W'(pl_ff[j]) + (NUM_W'(ph_ff[j]) << 32);
            flip3_ff[j] <= flip2_ff[j];
         end
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_div
      assign dside_in[j] = '{flip: flip3_ff[j], zero: zero3_ff};
      lmars_div u_div (
         .clock    (clock),
         .adv      (adv),
         .num      (n_ff[j]),
         .den      (den_ff),
         .side_in  (dside_in[j]),
         .quo      (quo[j]),
         .ovf      (ovf[j]),
         .side_out (dside_out[j])
      );
   end

   assign rate_in = lmars_clamp(quo[0], ovf[0], dside_out[0].flip, dside_out[0].zero,
                                cfg.vel_lim);
   assign ramp_in = lmars_clamp(quo[1], ovf[1], dside_out[1].flip, dside_out[1].zero,
                                cfg.acc_lim);

   always_ff @(posedge clock) begin
      if (adv) begin
         rate_ff <= rate_in;
         ramp_ff <= ramp_in;
         zero_ff <= dside_out[0].zero;
      end
   end

   assign rate = rate_ff;
   assign ramp = ramp_ff;
   assign zero = zero_ff;

endmodule

### rtl/linear_move_axis_rate_split.sv
// ----------------------------------------------------------------------------
// linear_move_axis_rate_split
// Splits a straight three-axis move into per-axis speed and acceleration.
// ----------------------------------------------------------------------------
// Input channel req_*: start and end point of one move, transferred when
// req_valid is high and req_stall low. Result channel rsp_*: clamped axis
// rates and ramps plus zero_length, transferred when rsp_valid is high and
// rsp_stall low. One result per move, in order.
// Stages, in order: deltas and squares, the sum and the bit-per-stage root,
// the products, the bit-per-stage dividers and the clamp, which is also the
// output register. Throughput is one move per cycle while the output is
// not stalled; every stage is a pipeline register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_stall rises; otherwise a new move is taken every cycle.
// Configuration writes on csr_* are always ready and are meant to be made
// while no move is in flight. Reset empties the pipeline and loads the
// register defaults (tool values 0, scales 1.0, limits 0); no clearing pass.
// ----------------------------------------------------------------------------
module linear_move_axis_rate_split (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_x_from,
   input  logic signed [31:0] req_x_to,
   input  logic signed [31:0] req_y_from,
   input  logic signed [31:0] req_y_to,
   input  logic signed [31:0] req_z_from,
   input  logic signed [31:0] req_z_to,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_x_rate,
   output logic signed [31:0] rsp_y_rate,
   output logic signed [31:0] rsp_z_rate,
   output logic signed [31:0] rsp_x_ramp,
   output logic signed [31:0] rsp_y_ramp,
   output logic signed [31:0] rsp_z_ramp,
   output logic               rsp_zero_length,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import lmars_pkg::*;

   logic [31:0]        tool_speed_ff, tool_accel_ff;
   logic [31:0]        scale_ff  [AXES];
   logic [63:0]        limits_ff [AXES];
   logic [LATENCY-1:0] vld_ff;
   logic               adv;
   logic [31:0]        from_pos [AXES];
   logic [31:0]        to_pos   [AXES];
   logic [SQ_W-1:0]    sq       [AXES];
   side_type           side_in, side_out;
   logic [ROOT_W-1:0]  len;
   axis_cfg_type       cfg      [AXES];
   logic [31:0]        rate     [AXES];
   logic [31:0]        ramp     [AXES];
   logic               zero     [AXES];

   assign csr_ready = 1'b1;
   assign adv       = !vld_ff[LATENCY-1] || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tool_speed_ff <= '0;
         tool_accel_ff <= '0;
         for (int a = 0; a < AXES; a++) begin
            scale_ff[a]  <= 32'h0001_0000;
            limits_ff[a] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_TOOL_SPEED: tool_speed_ff <= csr_data[31:0];
            REG_TOOL_ACCEL: tool_accel_ff <= csr_data[31:0];
            REG_X_SCALE:    scale_ff[0]   <= csr_data[31:0];
            REG_Y_SCALE:    scale_ff[1]   <= csr_data[31:0];
            REG_Z_SCALE:    scale_ff[2]   <= csr_data[31:0];
            REG_X_LIMITS:   limits_ff[0]  <= csr_data;
            REG_Y_LIMITS:   limits_ff[1]  <= csr_data;
            REG_Z_LIMITS:   limits_ff[2]  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   assign from_pos[0] = req_x_from;
   assign from_pos[1] = req_y_from;
   assign from_pos[2] = req_z_from;
   assign to_pos[0]   = req_x_to;
   assign to_pos[1]   = req_y_to;
   assign to_pos[2]   = req_z_to;

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      lmars_front u_front (
         .clock    (clock),
         .adv      (adv),
         .from_pos (from_pos[a]),
         .to_pos   (to_pos[a]),
         .neg      (side_in.neg[a]),
         .mag      (side_in.mag[a]),
         .sq       (sq[a])
      );

      assign cfg[a] = '{tool_speed: tool_speed_ff,
                        tool_accel: tool_accel_ff,
                        scale:      scale_ff[a],
                        vel_lim:    limits_ff[a][31:0],
                        acc_lim:    limits_ff[a][63:32]};

      lmars_axis u_axis (
         .clock (clock),
         .adv   (adv),
         .len   (len),
         .neg   (side_out.neg[a]),
         .mag   (side_out.mag[a]),
         .cfg   (cfg[a]),
         .rate  (rate[a]),
         .ramp  (ramp[a]),
         .zero  (zero[a])
      );
   end

   lmars_isqrt u_isqrt (
      .clock    (clock),
      .adv      (adv),
      .sq       (sq),
      .side_in  (side_in),
      .len      (len),
      .side_out (side_out)
   );

   assign rsp_valid       = vld_ff[LATENCY-1];
   assign rsp_x_rate      = rate[0];
   assign rsp_y_rate      = rate[1];
   assign rsp_z_rate      = rate[2];
   assign rsp_x_ramp      = ramp[0];
   assign rsp_y_ramp      = ramp[1];
   assign rsp_z_ramp      = ramp[2];
   assign rsp_zero_length = zero[0];

   // zero-length moves give all-zero rates
   a_zero_rates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> (rsp_x_rate == 32'sd0) && (rsp_y_rate == 32'sd0)
         && (rsp_z_rate == 32'sd0))
      else $error("zero-length move with nonzero rate");

   a_zero_ramps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> (rsp_x_ramp == 32'sd0) && (rsp_y_ramp == 32'sd0)
         && (rsp_z_ramp == 32'sd0))
      else $error("zero-length move with nonzero ramp");

   // a result one stage out always moves into an empty output register
   a_fill_output: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LATENCY-2] && !rsp_valid |=> rsp_valid)
      else $error("pipeline did not advance into empty output");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_move_axis_rate_split: a directed table of
// moves, then random moves under several register settings, each result
// checked against its typed result or the in-bench clamped axis rates.
// ----------------------------------------------------------------------------
module tb;
   import lmars_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] from;
      logic [2:0][31:0] to;
   } move_type;

   typedef struct packed {
      logic [2:0][31:0] rate;
      logic [2:0][31:0] ramp;
      logic             zl;
   } rates_type;

   typedef struct packed {
      move_type  mv;
      logic      typed;
      rates_type res;
   } dir_row_type;

   localparam int  LIMIT_CYCLES = 300000;
   localparam int  RAND_PHASES  = 6;
   localparam int  RAND_PER     = 225;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [31:0] req_x_from, req_x_to, req_y_from, req_y_to, req_z_from, req_z_to;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_x_rate, rsp_y_rate, rsp_z_rate;
   logic signed [31:0] rsp_x_ramp, rsp_y_ramp, rsp_z_ramp;
   logic rsp_zero_length;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [63:0] csr_data;

   logic [31:0] cfg_speed, cfg_accel;
   logic [2:0][31:0] cfg_scale;
   logic [2:0][63:0] cfg_lim;

   rates_type rates_due[$];
   dir_row_type dir_tab[$];
   int mismatches, results_seen, moves_sent, zero_seen, burst_left, hold_cycles;
   longint cycles;

   linear_move_axis_rate_split u_dut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("linear_move_axis_rate_split: mismatch");
         $finish;
      end
   end

   function automatic logic [31:0] axis_out(logic dneg, logic [32:0] dmag, logic [31:0] tool,
                                            logic [31:0] scale, logic [31:0] lim,
                                            logic [33:0] len);
      logic tneg;
      logic [32:0] tmag, m;
      logic [127:0] num, den, q;
      tneg = tool[31];
      tmag = tneg ? (33'h1_0000_0000 - {1'b0, tool}) : {1'b0, tool};
      num = 128'(dmag) * 128'(tmag) * 128'(scale);
      den = 128'(len) << 16;
      q = num / den;
      m = (q > 128'(lim)) ? {1'b0, lim} : q[32:0];
      if (m == 0) return 32'd0;
      if (dneg != tneg) begin
         if (m > 33'h8000_0000) m = 33'h8000_0000;
         return 32'(33'd0 - m);
      end
      if (m > 33'h7FFF_FFFF) m = 33'h7FFF_FFFF;
      return m[31:0];
   endfunction

   function automatic rates_type predict_rates(move_type mv);
      rates_type r;
      logic signed [32:0] d;
      logic [2:0] neg;
      logic [2:0][32:0] mag;
      logic [67:0] s;
      logic [33:0] root, c;
      s = 0;
      for (int a = 0; a < 3; a++) begin
         d = {mv.to[a][31], mv.to[a]} - {mv.from[a][31], mv.from[a]};
         neg[a] = d[32];
         mag[a] = neg[a] ? 33'(-d) : 33'(d);
         s += 68'(mag[a]) * 68'(mag[a]);
      end
      root = 0;
      for (int b = 33; b >= 0; b--) begin
         c = root | (34'd1 << b);
         if (68'(c) * 68'(c) <= s) root = c;
      end
      r = '0;
      if (root == 0) begin
         r.zl = 1'b1;
         return r;
      end
      for (int a = 0; a < 3; a++) begin
         r.rate[a] = axis_out(neg[a], mag[a], cfg_speed, cfg_scale[a], cfg_lim[a][31:0], root);
         r.ramp[a] = axis_out(neg[a], mag[a], cfg_accel, cfg_scale[a], cfg_lim[a][63:32], root);
      end
      return r;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      logic ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      case (idx)
         REG_TOOL_SPEED: cfg_speed = val[31:0];
         REG_TOOL_ACCEL: cfg_accel = val[31:0];
         REG_X_SCALE:    cfg_scale[0] = val[31:0];
         REG_Y_SCALE:    cfg_scale[1] = val[31:0];
         REG_Z_SCALE:    cfg_scale[2] = val[31:0];
         REG_X_LIMITS:   cfg_lim[0] = val;
         REG_Y_LIMITS:   cfg_lim[1] = val;
         REG_Z_LIMITS:   cfg_lim[2] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (rates_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one move, with the typed result if given, else the computed one
   task automatic send_move(move_type mv, logic typed, rates_type res);
      logic ok;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_valid  <= 1'b1;
      req_x_from <= mv.from[0];
      req_x_to   <= mv.to[0];
      req_y_from <= mv.from[1];
      req_y_to   <= mv.to[1];
      req_z_from <= mv.from[2];
      req_z_to   <= mv.to[2];
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      rates_due.push_back(typed ? res : predict_rates(mv));
      burst_left--;
      moves_sent++;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return MINV;
         1: return MAXV;
         2: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic move_type random_move();
      move_type mv;
      int kind;
      kind = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         mv.from[a] = $urandom;
         case (kind)
            0:       mv.to[a] = mv.from[a];
            1, 2, 3: mv.to[a] = $urandom;
            8:       mv.to[a] = (a == 0) ? 32'($urandom) : mv.from[a];
            9: begin
               mv.from[a] = pick_coord();
               mv.to[a] = pick_coord();
            end
            default: mv.to[a] = mv.from[a] + 32'($signed($urandom_range(0, 4000)) - 2000);
         endcase
      end
      return mv;
   endfunction

   function automatic logic [31:0] pick_cfg32(logic [31:0] dflt);
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return MINV;
         3: return MAXV;
         4: return dflt;
         5: return $urandom_range(0, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic move_type mk(int xf, int xt, int yf, int yt, int zf, int zt);
      move_type mv;
      mv.from = {32'(zf), 32'(yf), 32'(xf)};
      mv.to   = {32'(zt), 32'(yt), 32'(xt)};
      return mv;
   endfunction

   task automatic add_row(move_type mv, logic typed, rates_type res);
      dir_row_type row;
      row.mv = mv;
      row.typed = typed;
      row.res = res;
      dir_tab.push_back(row);
   endtask

   // result checker
   always @(posedge clock) begin
      rates_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.rate = {rsp_z_rate, rsp_y_rate, rsp_x_rate};
         got.ramp = {rsp_z_ramp, rsp_y_ramp, rsp_x_ramp};
         got.zl   = rsp_zero_length;
         results_seen++;
         if (got.zl) zero_seen++;
         if (rates_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
         end else begin
            want = rates_due.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d: exp rate %h %h %h ramp %h %h %h zl %b", results_seen,
                           want.rate[0], want.rate[1], want.rate[2],
                           want.ramp[0], want.ramp[1], want.ramp[2], want.zl);
                  $display("           got rate %h %h %h ramp %h %h %h zl %b",
                           got.rate[0], got.rate[1], got.rate[2],
                           got.ramp[0], got.ramp[1], got.ramp[2], got.zl);
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int seg, mode;
      rsp_stall = 1'b0;
      forever begin
         seg = $urandom_range(5, 80);
         mode = $urandom_range(0, 3);
         repeat (seg) begin
            @(posedge clock);
            if (hold_cycles > 0) begin
               rsp_stall <= 1'b1;
               hold_cycles--;
            end else case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= $urandom_range(0, 1);
            endcase
         end
      end
   end

   initial begin
      rates_type none, zero_res;
      cycles = 0;
      mismatches = 0;
      results_seen = 0;
      moves_sent = 0;
      zero_seen = 0;
      burst_left = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_x_from, req_x_to, req_y_from, req_y_to, req_z_from, req_z_to} = '0;
      csr_valid = 1'b0;
      csr_index = REG_TOOL_SPEED;
      csr_data = '0;
      cfg_speed = 0;
      cfg_accel = 0;
      cfg_scale = {3{32'd65536}};
      cfg_lim = '0;
      none = '0;
      zero_res = '0;
      zero_res.zl = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: tool values zero, so every rate reads zero
      add_row(mk(0, 0, 0, 0, 0, 0), 1, zero_res);
      add_row(mk(-5, -5, 7, 7, MAXV, MAXV), 1, zero_res);
      add_row(mk(0, 100, 0, 0, 0, 0), 1, none);
      add_row(mk(MINV, MAXV, MINV, MAXV, MINV, MAXV), 1, none);
      foreach (dir_tab[i]) send_move(dir_tab[i].mv, dir_tab[i].typed, dir_tab[i].res);
      settle();

      // extremes: saturation on x, tight clamp on y, zero scale with a wide clamp on z
      write_reg(REG_TOOL_SPEED, 64'(MINV));
      write_reg(REG_TOOL_ACCEL, 64'(MAXV));
      write_reg(REG_X_SCALE, 64'hFFFF_FFFF);
      write_reg(REG_Y_SCALE, 64'd65536);
      write_reg(REG_Z_SCALE, 64'd0);
      write_reg(REG_X_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_Y_LIMITS, 64'h0000_0064_0000_00C8);
      write_reg(REG_Z_LIMITS, 64'hFFFF_FFFF_7FFF_FFFF);
      dir_tab.delete();
      add_row(mk(3, 3, -9, -9, 0, 0), 1, zero_res);
      add_row(mk(MINV, MAXV, 0, 0, 0, 0), 0, none);
      add_row(mk(MAXV, MINV, 0, 0, 0, 0), 0, none);
      add_row(mk(0, 0, MINV, MAXV, 0, 0), 0, none);
      add_row(mk(0, 0, MAXV, MINV, MAXV, MINV), 0, none);
      add_row(mk(MINV, MAXV, MINV, MAXV, MINV, MAXV), 0, none);
      add_row(mk(MAXV, MINV, MINV, MAXV, MAXV, MINV), 0, none);
      add_row(mk(0, 1, 0, 1, 0, 1), 0, none);
      add_row(mk(0, -1, 0, 0, 0, 0), 0, none);
      add_row(mk(-1, 0, 5, 3, 100, -100), 0, none);
      add_row(mk(1000, 4000, 2000, 6000, 0, 0), 0, none);
      add_row(mk(-2, -3, 1, 1, 0, 2), 0, none);
      add_row(mk(12345, -6789, 777, 8888, -4, 99999), 0, none);
      foreach (dir_tab[i]) send_move(dir_tab[i].mv, dir_tab[i].typed, dir_tab[i].res);
      settle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         write_reg(REG_TOOL_SPEED, 64'(pick_cfg32($urandom_range(1, 50000))));
         write_reg(REG_TOOL_ACCEL, 64'(pick_cfg32($urandom_range(1, 500000))));
         write_reg(REG_X_SCALE, 64'(pick_cfg32(32'd65536)));
         write_reg(REG_Y_SCALE, 64'(pick_cfg32(32'd65536)));
         write_reg(REG_Z_SCALE, 64'(pick_cfg32(32'd65536)));
         write_reg(REG_X_LIMITS, {pick_cfg32(32'hFFFF_FFFF), pick_cfg32(32'hFFFF_FFFF)});
         write_reg(REG_Y_LIMITS, {pick_cfg32(32'hFFFF_FFFF), pick_cfg32(32'hFFFF_FFFF)});
         write_reg(REG_Z_LIMITS, {pick_cfg32(32'hFFFF_FFFF), pick_cfg32(32'hFFFF_FFFF)});
         if (p == 1) hold_cycles = 400;
         repeat (RAND_PER) send_move(random_move(), 0, none);
         settle();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (rates_due.size() != 0) begin
         mismatches += rates_due.size();
         $display("%0d expected results never arrived", rates_due.size());
      end
      $display("%0d moves sent, %0d results checked (%0d zero length), %0d register settings",
               moves_sent, results_seen, zero_seen, RAND_PHASES + 2);
      if (mismatches == 0) begin
         $display("linear_move_axis_rate_split: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("linear_move_axis_rate_split: mismatch");
      end
      $finish;
   end

endmodule
